// ===== src/gn3d_pkg.sv =====
// Shared types, constants and arithmetic helpers for the 3D gradient noise block.
// Used by gn3d_ram, gradient_noise_3d_eval and gn3d_checker; depends on nothing.
package gn3d_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int COORD_W    = 32;
    localparam int OUT_W      = 18;
    localparam int OUT_FRAC   = 16;
    localparam int VAL_W      = FRAC_BITS + 6;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int WIDE_W     = VAL_W + 9;

    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic signed [VAL_W-1:0]   t_val;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic signed [COORD_W:0]   t_coord;

    localparam t_coord OFFSET_Q = t_coord'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam t_val   ONE_Q    = t_val'(64'd1 << FRAC_BITS);
    localparam t_prod  HALF_Q   = t_prod'(64'd1 << (FRAC_BITS - 1));

    localparam int FADE_K6  = 6;
    localparam int FADE_K15 = 15;
    localparam int FADE_K10 = 10;

    localparam logic [3:0] GRAD_USE_Y = 4'd8;
    localparam logic [3:0] GRAD_V_Y   = 4'd4;
    localparam logic [3:0] GRAD_X_12  = 4'd12;
    localparam logic [3:0] GRAD_X_14  = 4'd14;

    localparam int    SH_DN  = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
    localparam int    SH_UP  = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
    localparam t_wide RND_DN = (FRAC_BITS > OUT_FRAC) ?
                               t_wide'(64'd1 << (FRAC_BITS - OUT_FRAC - 1)) : t_wide'(0);
    localparam t_wide OUT_MAX = t_wide'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam t_wide OUT_MIN = -t_wide'(64'd1 << (OUT_W - 1));

    function automatic t_prod qmul_raw(input t_val a, input t_val b);
        return t_prod'(a) * t_prod'(b);
    endfunction

    function automatic t_val qround(input t_prod p);
        t_prod s;
        s = (p + HALF_Q) >>> FRAC_BITS;
        return s[VAL_W-1:0];
    endfunction

    function automatic t_val grad(input t_idx hash, input t_val x, input t_val y,
                                  input t_val z);
        logic [3:0] h;
        t_val       u;
        t_val       v;
        h = hash[3:0];
        u = (h < GRAD_USE_Y) ? x : y;
        v = (h < GRAD_V_Y) ? y : (((h == GRAD_X_12) || (h == GRAD_X_14)) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

// ===== src/gradient_noise_3d_eval.sv =====
// Top level of the 3D gradient noise evaluator: an eleven-stage pipeline.
// Depends on gn3d_pkg and gn3d_ram.
//
// Input channel: i_valid / o_ready carry one word with i_action and its fields.
// A load word (action 0) writes i_entry_value into table entry i_entry_index
// and yields no result. An evaluate word (action 1) yields one o_noise_value
// in signed Q2.16 on the o_valid / i_ready channel, in order.
// One word enters per cycle unless a result word waits on a stalled receiver;
// the stage count is set by the multiplier chain of the fade and the three lerp
// levels, each multiply and each rounding add given its own stage.
// The table is held in seven copies, each with two read ports; a load word
// writes each copy as it passes the stage that reads that copy, so words
// before and after a load see the table in the order they were given.
// Reset clears the stage valid bits only; table contents are undefined until
// loaded. When the receiver stalls, the whole pipeline holds and o_ready
// falls unless the output register holds no result word.
module gradient_noise_3d_eval (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_action,
    input  logic [7:0]                          i_entry_index,
    input  logic [7:0]                          i_entry_value,
    input  logic signed [31:0]                  i_x_coord,
    input  logic signed [31:0]                  i_y_coord,
    input  logic signed [31:0]                  i_z_coord,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [gn3d_pkg::OUT_W-1:0]   o_noise_value
);

    localparam int F = gn3d_pkg::FRAC_BITS;
    localparam int IW = gn3d_pkg::IDX_W;
    localparam int NS = 11;

    logic en;
    logic [NS:1] r_vld;
    logic [NS:1] r_eval;

    gn3d_pkg::t_coord c_in [3];
    gn3d_pkg::t_idx   r1_cell [3];
    gn3d_pkg::t_val   r1_frac [3];
    gn3d_pkg::t_idx   r1_idx, r2_idx, r3_idx;
    logic [7:0]       r1_val, r2_val, r3_val;

    gn3d_pkg::t_idx   r2_cell1, r2_cell2, r3_cell2;
    gn3d_pkg::t_val   r2_frac [3];
    gn3d_pkg::t_val   r3_frac [3];
    gn3d_pkg::t_val   r4_frac [3];
    gn3d_pkg::t_prod  r2_ta [3];
    gn3d_pkg::t_prod  r2_tt [3];
    gn3d_pkg::t_prod  r3_c [3];
    gn3d_pkg::t_prod  r3_t3 [3];
    gn3d_pkg::t_prod  r4_g [3];
    gn3d_pkg::t_val   r5_fade [3];
    gn3d_pkg::t_val   r5_grad [8];
    gn3d_pkg::t_val   r6_a [4];
    gn3d_pkg::t_prod  r6_p [4];
    gn3d_pkg::t_val   r6_v, r6_w, r7_v, r7_w, r8_w, r9_w;
    gn3d_pkg::t_val   r7_l1 [4];
    gn3d_pkg::t_val   r8_a [2];
    gn3d_pkg::t_prod  r8_p [2];
    gn3d_pkg::t_val   r9_l2 [2];
    gn3d_pkg::t_val   r10_a;
    gn3d_pkg::t_prod  r10_p;
    logic signed [gn3d_pkg::OUT_W-1:0] r_out;

    logic [7:0]     pa, pb, pa0, pa1, pb0, pb1;
    logic [7:0]     h [8];
    gn3d_pkg::t_idx a_addr, b_addr, aa, ab, ba, bb;
    gn3d_pkg::t_val x1, y1, z1, sum;
    gn3d_pkg::t_wide scaled;
    logic we1, we2, we3;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NS] && r_eval[NS];
    assign o_noise_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_eval <= {r_eval[NS-1:1], i_action};
        end
    end

    assign c_in[0] = gn3d_pkg::t_coord'(i_x_coord) + gn3d_pkg::OFFSET_Q;
    assign c_in[1] = gn3d_pkg::t_coord'(i_y_coord) + gn3d_pkg::OFFSET_Q;
    assign c_in[2] = gn3d_pkg::t_coord'(i_z_coord) + gn3d_pkg::OFFSET_Q;

    assign we1 = r_vld[1] && !r_eval[1];
    assign we2 = r_vld[2] && !r_eval[2];
    assign we3 = r_vld[3] && !r_eval[3];

    gn3d_ram u_bank0 (
        .i_clk(i_clk), .i_en(en), .i_we(we1), .i_wr_addr(r1_idx), .i_wr_data(r1_val),
        .i_rd_addr_a(r1_cell[0]), .i_rd_addr_b(r1_cell[0] + IW'(1)),
        .o_rd_data_a(pa), .o_rd_data_b(pb)
    );

    assign a_addr = pa + r2_cell1;
    assign b_addr = pb + r2_cell1;

    gn3d_ram u_bank1 (
        .i_clk(i_clk), .i_en(en), .i_we(we2), .i_wr_addr(r2_idx), .i_wr_data(r2_val),
        .i_rd_addr_a(a_addr), .i_rd_addr_b(a_addr + IW'(1)),
        .o_rd_data_a(pa0), .o_rd_data_b(pa1)
    );

    gn3d_ram u_bank2 (
        .i_clk(i_clk), .i_en(en), .i_we(we2), .i_wr_addr(r2_idx), .i_wr_data(r2_val),
        .i_rd_addr_a(b_addr), .i_rd_addr_b(b_addr + IW'(1)),
        .o_rd_data_a(pb0), .o_rd_data_b(pb1)
    );

    assign aa = pa0 + r3_cell2;
    assign ab = pa1 + r3_cell2;
    assign ba = pb0 + r3_cell2;
    assign bb = pb1 + r3_cell2;

    gn3d_ram u_bank3 (
        .i_clk(i_clk), .i_en(en), .i_we(we3), .i_wr_addr(r3_idx), .i_wr_data(r3_val),
        .i_rd_addr_a(aa), .i_rd_addr_b(aa + IW'(1)),
        .o_rd_data_a(h[0]), .o_rd_data_b(h[4])
    );

    gn3d_ram u_bank4 (
        .i_clk(i_clk), .i_en(en), .i_we(we3), .i_wr_addr(r3_idx), .i_wr_data(r3_val),
        .i_rd_addr_a(ba), .i_rd_addr_b(ba + IW'(1)),
        .o_rd_data_a(h[1]), .o_rd_data_b(h[5])
    );

    gn3d_ram u_bank5 (
        .i_clk(i_clk), .i_en(en), .i_we(we3), .i_wr_addr(r3_idx), .i_wr_data(r3_val),
        .i_rd_addr_a(ab), .i_rd_addr_b(ab + IW'(1)),
        .o_rd_data_a(h[2]), .o_rd_data_b(h[6])
    );

    gn3d_ram u_bank6 (
        .i_clk(i_clk), .i_en(en), .i_we(we3), .i_wr_addr(r3_idx), .i_wr_data(r3_val),
        .i_rd_addr_a(bb), .i_rd_addr_b(bb + IW'(1)),
        .o_rd_data_a(h[3]), .o_rd_data_b(h[7])
    );

    assign x1 = r4_frac[0] - gn3d_pkg::ONE_Q;
    assign y1 = r4_frac[1] - gn3d_pkg::ONE_Q;
    assign z1 = r4_frac[2] - gn3d_pkg::ONE_Q;

    always_comb begin
        sum = r10_a + gn3d_pkg::qround(r10_p);
        if (F > gn3d_pkg::OUT_FRAC) begin
            scaled = (gn3d_pkg::t_wide'(sum) + gn3d_pkg::RND_DN) >>> gn3d_pkg::SH_DN;
        end else begin
            scaled = gn3d_pkg::t_wide'(sum) <<< gn3d_pkg::SH_UP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_idx <= i_entry_index;
            r1_val <= i_entry_value;
            r2_idx <= r1_idx;
            r2_val <= r1_val;
            r3_idx <= r2_idx;
            r3_val <= r2_val;
            r2_cell1 <= r1_cell[1];
            r2_cell2 <= r1_cell[2];
            r3_cell2 <= r2_cell2;
            for (int k = 0; k < 3; k++) begin
                r1_cell[k] <= c_in[k][F+IW-1:F];
                r1_frac[k] <= gn3d_pkg::t_val'({1'b0, c_in[k][F-1:0]});
                r2_frac[k] <= r1_frac[k];
                r3_frac[k] <= r2_frac[k];
                r4_frac[k] <= r3_frac[k];
                r2_ta[k] <= gn3d_pkg::qmul_raw(r1_frac[k],
                    gn3d_pkg::t_val'(r1_frac[k] * gn3d_pkg::FADE_K6)
                    - gn3d_pkg::t_val'(gn3d_pkg::ONE_Q * gn3d_pkg::FADE_K15));
                r2_tt[k] <= gn3d_pkg::qmul_raw(r1_frac[k], r1_frac[k]);
                r3_c[k]  <= gn3d_pkg::qmul_raw(r2_frac[k], gn3d_pkg::qround(r2_ta[k])
                    + gn3d_pkg::t_val'(gn3d_pkg::ONE_Q * gn3d_pkg::FADE_K10));
                r3_t3[k] <= gn3d_pkg::qmul_raw(gn3d_pkg::qround(r2_tt[k]), r2_frac[k]);
                r4_g[k]  <= gn3d_pkg::qmul_raw(gn3d_pkg::qround(r3_t3[k]),
                                               gn3d_pkg::qround(r3_c[k]));
                r5_fade[k] <= gn3d_pkg::qround(r4_g[k]);
            end
            r5_grad[0] <= gn3d_pkg::grad(h[0], r4_frac[0], r4_frac[1], r4_frac[2]);
            r5_grad[1] <= gn3d_pkg::grad(h[1], x1, r4_frac[1], r4_frac[2]);
            r5_grad[2] <= gn3d_pkg::grad(h[2], r4_frac[0], y1, r4_frac[2]);
            r5_grad[3] <= gn3d_pkg::grad(h[3], x1, y1, r4_frac[2]);
            r5_grad[4] <= gn3d_pkg::grad(h[4], r4_frac[0], r4_frac[1], z1);
            r5_grad[5] <= gn3d_pkg::grad(h[5], x1, r4_frac[1], z1);
            r5_grad[6] <= gn3d_pkg::grad(h[6], r4_frac[0], y1, z1);
            r5_grad[7] <= gn3d_pkg::grad(h[7], x1, y1, z1);
            for (int j = 0; j < 4; j++) begin
                r6_a[j] <= r5_grad[2*j];
                r6_p[j] <= gn3d_pkg::qmul_raw(r5_fade[0], r5_grad[2*j+1] - r5_grad[2*j]);
                r7_l1[j] <= r6_a[j] + gn3d_pkg::qround(r6_p[j]);
            end
            r6_v <= r5_fade[1];
            r6_w <= r5_fade[2];
            r7_v <= r6_v;
            r7_w <= r6_w;
            r8_w <= r7_w;
            r9_w <= r8_w;
            for (int j = 0; j < 2; j++) begin
                r8_a[j] <= r7_l1[2*j];
                r8_p[j] <= gn3d_pkg::qmul_raw(r7_v, r7_l1[2*j+1] - r7_l1[2*j]);
                r9_l2[j] <= r8_a[j] + gn3d_pkg::qround(r8_p[j]);
            end
            r10_a <= r9_l2[0];
            r10_p <= gn3d_pkg::qmul_raw(r9_w, r9_l2[1] - r9_l2[0]);
            if (scaled > gn3d_pkg::OUT_MAX) begin
                r_out <= gn3d_pkg::OUT_MAX[gn3d_pkg::OUT_W-1:0];
            end else if (scaled < gn3d_pkg::OUT_MIN) begin
                r_out <= gn3d_pkg::OUT_MIN[gn3d_pkg::OUT_W-1:0];
            end else begin
                r_out <= scaled[gn3d_pkg::OUT_W-1:0];
            end
        end
    end

endmodule

// ===== src/gn3d_ram.sv =====
// One copy of the 256 x 8 permutation table: one write port, two registered read ports.
// Depends on gn3d_pkg for the index type.
module gn3d_ram (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_we,
    input  gn3d_pkg::t_idx     i_wr_addr,
    input  logic [7:0]         i_wr_data,
    input  gn3d_pkg::t_idx     i_rd_addr_a,
    input  gn3d_pkg::t_idx     i_rd_addr_b,
    output logic [7:0]         o_rd_data_a,
    output logic [7:0]         o_rd_data_b
);

    logic [7:0] r_mem [gn3d_pkg::TABLE_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

// ===== src/gn3d_checker.sv =====
// Port-level checks for gradient_noise_3d_eval, attached by the bind below.
// Depends on gn3d_pkg for the output width.
module gn3d_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [gn3d_pkg::OUT_W-1:0]        o_noise_value
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_noise_value))
        else $error("Result word changed while stalled.");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("Input ready disagrees with output stall.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result word shown straight after reset.");

endmodule

bind gradient_noise_3d_eval gn3d_checker u_gn3d_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_noise_value(o_noise_value)
);

// ===== sim/gradient_noise_3d_eval_test.sv =====
// Self-checking testbench for gradient_noise_3d_eval: table loads, directed and random
// evaluate words, checked against an in-bench fixed-point noise predictor.
// Depends on gn3d_pkg and the gradient_noise_3d_eval RTL.
module gradient_noise_3d_eval_test;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;
    localparam longint ONE = 64'sd1 << gn3d_pkg::FRAC_BITS;
    localparam longint OFFS = ((64'sd1 << gn3d_pkg::FRAC_BITS) + 5000) / 10000;
    localparam longint RND = (64'sd1 << gn3d_pkg::SH_DN) >>> 1;
    localparam int N_RANDOM = 1380;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic i_action;
    logic [7:0] i_entry_index;
    logic [7:0] i_entry_value;
    logic signed [31:0] i_x_coord;
    logic signed [31:0] i_y_coord;
    logic signed [31:0] i_z_coord;
    logic o_valid;
    logic i_ready;
    logic signed [gn3d_pkg::OUT_W-1:0] o_noise_value;

    typedef struct {
        logic act;
        logic [7:0] idx;
        logic [7:0] val;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit has_known;
        logic signed [gn3d_pkg::OUT_W-1:0] known;
    } t_word;

    logic [7:0] shadow_perm [256];
    logic signed [gn3d_pkg::OUT_W-1:0] pending_noise [$];
    t_word words [$];
    int mismatches;
    int cycles;
    bit stim_done;

    gradient_noise_3d_eval dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint fshift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint qm(longint a, longint b);
        return fshift(a * b + (ONE >>> 1), gn3d_pkg::FRAC_BITS);
    endfunction

    function automatic longint fade(longint t);
        longint a;
        longint b;
        longint c;
        a = t * 6 - 15 * ONE;
        b = qm(t, a) + 10 * ONE;
        c = qm(t, b);
        return qm(qm(qm(t, t), t), c);
    endfunction

    function automatic longint lerp(longint t, longint a, longint b);
        return a + qm(t, b - a);
    endfunction

    function automatic longint gdot(logic [7:0] hs, longint x, longint y, longint z);
        logic [3:0] h;
        longint u;
        longint v;
        h = hs[3:0];
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic [7:0] pt(int i);
        return shadow_perm[i & 255];
    endfunction

    function automatic logic signed [gn3d_pkg::OUT_W-1:0] noise_at(logic [31:0] xc,
                                                                  logic [31:0] yc,
                                                                  logic [31:0] zc);
        longint c [3];
        longint f [3];
        longint g [3];
        int cl [3];
        int a, b, aa, ab, ba, bb;
        longint x1, y1, z1, r;
        c[0] = longint'(signed'(xc)) + OFFS;
        c[1] = longint'(signed'(yc)) + OFFS;
        c[2] = longint'(signed'(zc)) + OFFS;
        for (int k = 0; k < 3; k++) begin
            cl[k] = int'((c[k] >>> gn3d_pkg::FRAC_BITS) & 255);
            f[k] = c[k] & (ONE - 1);
            g[k] = fade(f[k]);
        end
        x1 = f[0] - ONE;
        y1 = f[1] - ONE;
        z1 = f[2] - ONE;
        a = pt(cl[0]) + cl[1];
        aa = pt(a) + cl[2];
        ab = pt(a + 1) + cl[2];
        b = pt(cl[0] + 1) + cl[1];
        ba = pt(b) + cl[2];
        bb = pt(b + 1) + cl[2];
        r = lerp(g[2],
            lerp(g[1],
                lerp(g[0], gdot(pt(aa), f[0], f[1], f[2]), gdot(pt(ba), x1, f[1], f[2])),
                lerp(g[0], gdot(pt(ab), f[0], y1, f[2]), gdot(pt(bb), x1, y1, f[2]))),
            lerp(g[1],
                lerp(g[0], gdot(pt(aa + 1), f[0], f[1], z1),
                    gdot(pt(ba + 1), x1, f[1], z1)),
                lerp(g[0], gdot(pt(ab + 1), f[0], y1, z1),
                    gdot(pt(bb + 1), x1, y1, z1))));
        if (gn3d_pkg::FRAC_BITS > gn3d_pkg::OUT_FRAC)
            r = fshift(r + RND, gn3d_pkg::SH_DN);
        else
            r = r <<< gn3d_pkg::SH_UP;
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r[gn3d_pkg::OUT_W-1:0];
    endfunction

    function automatic t_word mk(logic act, logic [7:0] idx, logic [7:0] val,
                                 logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_word w;
        w.act = act;
        w.idx = idx;
        w.val = val;
        w.x = x;
        w.y = y;
        w.z = z;
        w.has_known = 1'b0;
        w.known = '0;
        return w;
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send(t_word w);
        i_valid <= 1'b1;
        i_action <= w.act;
        i_entry_index <= w.idx;
        i_entry_value <= w.val;
        i_x_coord <= w.x;
        i_y_coord <= w.y;
        i_z_coord <= w.z;
        do @(posedge i_clk); while (!o_ready);
        if (w.act == ACT_LOAD) begin
            shadow_perm[w.idx] = w.val;
        end else begin
            pending_noise.push_back(w.has_known ? w.known : noise_at(w.x, w.y, w.z));
        end
    endtask

    task automatic idle(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        t_word w;
        int burst;
        int nsent;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_LOAD;
        i_entry_index = '0;
        i_entry_value = '0;
        i_x_coord = '0;
        i_y_coord = '0;
        i_z_coord = '0;
        stim_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: an all-zero table gives zero noise at integer-aligned points,
        // then every entry is loaded before any lookup that could touch it.
        for (int i = 0; i < 256; i++) words.push_back(mk(ACT_LOAD, 8'(i), 8'h00, '1, '1, '1));
        w = mk(ACT_EVAL, 8'hFF, 8'hFF, 32'hFFFF_FFF9, 32'hFFFF_FFF9, 32'hFFFF_FFF9);
        w.has_known = 1'b1;
        w.known = '0;
        words.push_back(w);
        for (int i = 0; i < 256; i++)
            words.push_back(mk(ACT_LOAD, 8'(i), 8'(i * 37 + 11), '0, '0, '0));
        words.push_back(mk(ACT_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000));
        words.push_back(mk(ACT_EVAL, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF));
        words.push_back(mk(ACT_EVAL, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000,
                           32'h0000_0000));
        words.push_back(mk(ACT_EVAL, 8'h00, 8'h00, 32'h0000_8000, 32'h0000_8000,
                           32'h0000_8000));
        words.push_back(mk(ACT_EVAL, 8'h00, 8'h00, 32'hFFFF_FFF8, 32'h0000_FFF8,
                           32'h00FF_FFFF));
        words.push_back(mk(ACT_EVAL, 8'h00, 8'h00, 32'h0100_0000, 32'hFF00_0000,
                           32'h0000_FFF9));

        nsent = 0;
        while (words.size() > 0) begin
            w = words.pop_front();
            send(w);
            nsent++;
            if (nsent > 512 && $urandom_range(0, 3) == 0) idle($urandom_range(1, 3));
        end

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
                if ($urandom_range(0, 19) == 0)
                    w = mk(ACT_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
                else
                    w = mk(ACT_EVAL, 8'($urandom), 8'($urandom), rnd_coord(), rnd_coord(),
                           rnd_coord());
                send(w);
            end
            if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall pattern, with one long hold-off early in the random part.
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (cycles == 900) begin
                i_ready <= 1'b0;
                repeat (60) @(posedge i_clk);
            end
            if ((cycles / 300) % 3 == 0)
                i_ready <= 1'b1;
            else
                i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_noise.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: noise %0d", o_noise_value);
            end else if (pending_noise[0] !== o_noise_value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("noise mismatch: expected %0d, got %0d", pending_noise[0],
                             o_noise_value);
                void'(pending_noise.pop_front());
            end else begin
                void'(pending_noise.pop_front());
            end
        end
    end

    initial begin
        mismatches = 0;
        cycles = 0;
        while (!(stim_done && pending_noise.size() == 0) && cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("gradient_noise_3d_eval_test: FAIL");
        end else begin
            repeat (30) @(posedge i_clk);
            if (mismatches == 0 && pending_noise.size() == 0)
                $display("gradient_noise_3d_eval_test: PASS");
            else
                $display("gradient_noise_3d_eval_test: FAIL");
        end
        $finish;
    end
endmodule
